>>> rtl/slm_pkg.sv
`timescale 1ns / 1ps
package slm_pkg;

	localparam int MAX_BLOCK_SAMPLES_DEF = 1024;
	localparam int AVERAGE_WINDOW_DEF    = 600;

	localparam int SAMPLE_W = 16;
	localparam int SECS_W   = 8;
	localparam int LEVEL_W  = 11;
	localparam int BAND_W   = 3;
	localparam int COUNT_W  = 32;
	localparam int CAL_W    = 9;
	localparam int REG_IDX_W = 2;
	localparam int REG_DATA_W = 9;

	localparam int MANT_W     = 31;
	localparam int FRAC_W     = 16;
	localparam int SQR_ROUNDS = 16;
	localparam int LOG_SCALE_Q16 = 1972830;
	localparam int LOG_BIAS   = 30;
	localparam int LEVEL_REF  = 940;
	localparam int LEVEL_MIN  = 300;
	localparam int LEVEL_MAX  = 1400;

	localparam logic [LEVEL_W-1:0] TH_ELEVATED  = 11'd850;
	localparam logic [LEVEL_W-1:0] TH_WARNING   = 11'd900;
	localparam logic [LEVEL_W-1:0] TH_EXPOSE_LO = 11'd950;
	localparam logic [LEVEL_W-1:0] TH_CRITICAL  = 11'd1050;
	localparam logic [LEVEL_W-1:0] TH_EXPOSE_HI = 11'd1100;
	localparam logic [LEVEL_W-1:0] TH_DANGEROUS = 11'd1200;
	localparam logic [LEVEL_W-1:0] TH_IMPACT    = 11'd1300;

	localparam logic [BAND_W-1:0] BAND_NORMAL    = 3'd0;
	localparam logic [BAND_W-1:0] BAND_ELEVATED  = 3'd1;
	localparam logic [BAND_W-1:0] BAND_WARNING   = 3'd2;
	localparam logic [BAND_W-1:0] BAND_CRITICAL  = 3'd3;
	localparam logic [BAND_W-1:0] BAND_DANGEROUS = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_MEASURE_ENABLE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ALERT_ENABLE   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CAL_OFFSET     = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
		logic [SECS_W-1:0]          elapsed_seconds;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level_tenths;
		logic [BAND_W-1:0]  level_band;
		logic [LEVEL_W-1:0] average_tenths;
		logic [LEVEL_W-1:0] peak_tenths;
		logic [COUNT_W-1:0] exposure_95_seconds;
		logic [COUNT_W-1:0] exposure_110_seconds;
		logic [COUNT_W-1:0] impact_count;
		logic               alert;
	} out_item_t;

endpackage

>>> rtl/slm_in_if.sv
`timescale 1ns / 1ps
interface slm_in_if;
	logic              valid;
	logic              ready;
	slm_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/slm_out_if.sv
`timescale 1ns / 1ps
interface slm_out_if;
	logic               valid;
	logic               ready;
	slm_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/slm_cfg_if.sv
`timescale 1ns / 1ps
interface slm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [slm_pkg::REG_IDX_W-1:0]    index;
	logic [slm_pkg::REG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/sound_level_meter_with_exposure_unit.sv
`timescale 1ns / 1ps
// Sound level meter with exposure statistics.
// samples: one request per microphone sample; last closes a measurement block and
// carries the seconds elapsed since the previous block. While measure_enable is low,
// requests are taken and dropped. Samples of an open block are taken one per cycle.
// results: one request per closed block with level, band, rolling average, peak,
// exposure seconds, impact count and alert. It is held in an output register until
// taken; a stalled receiver only blocks the end of the following block.
// cfg: register writes, always ready, index 0 measure_enable, 1 alert_enable,
// 2 calibration_offset_tenths.
// After a last sample the block stops taking samples while it works out the level:
// a one-bit-per-cycle normalizer and SQR_ROUNDS squaring rounds of the 31-bit
// mantissa multiplier, once for the square sum and again for the count; then the
// scaling, level and history-update states, a state that multiplies the window
// total by the reciprocal of the window size, and a state that loads the result
// register once the output is free. A silent block skips the logarithm. The
// history store is a 600-entry memory with a registered read; a wrap flag makes
// entries read as zero until the first full pass, so reset needs no clearing
// sweep and all counters restart at zero at once.
module sound_level_meter_with_exposure_unit #(
	parameter int MAX_BLOCK_SAMPLES = slm_pkg::MAX_BLOCK_SAMPLES_DEF,
	parameter int AVERAGE_WINDOW    = slm_pkg::AVERAGE_WINDOW_DEF
) (
	input logic      clk,
	input logic      arst_n,
	slm_in_if.sink   samples,
	slm_out_if.source results,
	slm_cfg_if.sink  cfg
);

	localparam int SUM_W  = 31 + $clog2(MAX_BLOCK_SAMPLES);
	localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
	localparam int EXP_W  = $clog2(SUM_W);
	localparam int LG_W   = EXP_W + slm_pkg::FRAC_W;
	localparam int DW     = LG_W + 2;
	localparam int PW     = DW + 22;
	localparam int IW     = PW - 30;
	localparam int POS_W  = (AVERAGE_WINDOW > 1) ? $clog2(AVERAGE_WINDOW) : 1;
	localparam int TOT_W  = $clog2(slm_pkg::LEVEL_MAX * AVERAGE_WINDOW + 1);
	localparam int RND_W  = $clog2(slm_pkg::SQR_ROUNDS);
	localparam int LW     = slm_pkg::LEVEL_W;
	localparam int CW     = slm_pkg::COUNT_W;

	// The reciprocal is rounded up with enough fraction bits that the quotient is
	// exact for every total that fits in TOT_W bits.
	localparam int REC_SH = TOT_W + $clog2(AVERAGE_WINDOW);
	localparam int REC_W  = TOT_W + 1;
	localparam int AP_W   = TOT_W + REC_W;
	localparam logic [REC_W-1:0] REC_M =
		REC_W'(((64'd1 << REC_SH) + 64'(AVERAGE_WINDOW) - 64'd1) / 64'(AVERAGE_WINDOW));

	localparam logic [2:0] S_ACC  = 3'd0;
	localparam logic [2:0] S_NORM = 3'd1;
	localparam logic [2:0] S_SQR  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_LVL  = 3'd4;
	localparam logic [2:0] S_HIST = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	localparam logic signed [21:0] K_S = 22'(slm_pkg::LOG_SCALE_Q16);

	logic [2:0] state_q;

	logic                           meas_en_q;
	logic                           alert_en_q;
	logic signed [slm_pkg::CAL_W-1:0] cal_off_q;

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  blk_cnt_q;
	logic [SUM_W-1:0]  norm_q;
	logic [EXP_W-1:0]  exp_q;
	logic [slm_pkg::MANT_W-1:0] mant_q;
	logic [slm_pkg::FRAC_W-1:0] frac_q;
	logic [RND_W-1:0]  rnd_q;
	logic              which_q;
	logic [LG_W-1:0]   lg_sum_q;
	logic [LG_W-1:0]   lg_cnt_q;
	logic signed [PW-1:0] prod_q;
	logic [LW-1:0]     level_q;
	logic [LW-1:0]     hist_mem [AVERAGE_WINDOW];
	logic [LW-1:0]     hist_rd_q;
	logic [POS_W-1:0]  pos_q;
	logic              wrapped_q;
	logic [TOT_W-1:0]  total_q;
	logic [LW-1:0]     div_q;
	logic [LW-1:0]     peak_q;
	logic [CW-1:0]     exp95_q;
	logic [CW-1:0]     exp110_q;
	logic [CW-1:0]     impacts_q;
	logic [slm_pkg::BAND_W-1:0] alert_mem_q;
	logic              seen_q;
	logic [slm_pkg::SECS_W-1:0] secs_q;
	slm_pkg::out_item_t out_q;
	logic              out_valid_q;

	logic                     in_fire;
	logic signed [31:0]       sq_s;
	logic [SUM_W-1:0]         sum_next;
	logic [CNT_W-1:0]         cnt_next;
	logic                     take;
	logic [61:0]              msq;
	logic [31:0]              msh;
	logic [slm_pkg::MANT_W-1:0] mant_next;
	logic [slm_pkg::FRAC_W-1:0] frac_next;
	logic signed [DW-1:0]     d_w;
	logic signed [PW:0]       t_w;
	logic signed [IW-1:0]     lvl_w;
	logic [LW-1:0]            lvl_clamped;
	logic [LW-1:0]            old_w;
	logic [TOT_W-1:0]         total_next;
	logic [AP_W-1:0]          avg_prod;
	logic                     fin_go;
	logic [slm_pkg::BAND_W-1:0] band_w;
	logic [LW-1:0]            peak_next;
	logic [CW-1:0]            exp95_next;
	logic [CW-1:0]            exp110_next;
	logic [CW-1:0]            impacts_next;
	logic [CW:0]              add95;
	logic [CW:0]              add110;
	logic [CW:0]              addimp;
	logic                     alert_w;
	logic [slm_pkg::BAND_W-1:0] alert_mem_next;

	assign samples.ready = (state_q == S_ACC);
	assign cfg.ready     = 1'b1;
	assign in_fire       = samples.valid && samples.ready;
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	// Accumulation of squares; samples past the block limit are dropped.
	assign sq_s     = samples.data.sample * samples.data.sample;
	assign take     = (cnt_q < CNT_W'(MAX_BLOCK_SAMPLES));
	assign sum_next = take ? sum_q + SUM_W'(unsigned'(sq_s)) : sum_q;
	assign cnt_next = take ? cnt_q + CNT_W'(1) : cnt_q;

	// One squaring round of the log2 fraction.
	assign msq       = mant_q * mant_q;
	assign msh       = msq[61:30];
	assign mant_next = msh[31] ? msh[31:1] : msh[30:0];
	assign frac_next = {frac_q[slm_pkg::FRAC_W-2:0], msh[31]};

	assign d_w = signed'({2'b00, lg_sum_q}) - signed'({2'b00, lg_cnt_q})
		- DW'(slm_pkg::LOG_BIAS * (1 << slm_pkg::FRAC_W));

	// Round half up in Q32, then floor; the integer offset commutes with the floor.
	assign t_w   = {prod_q[PW-1], prod_q} + (PW+1)'(64'sd2147483648);
	assign lvl_w = IW'($signed(t_w[PW:32])) + IW'(cal_off_q) + IW'(slm_pkg::LEVEL_REF);

	always_comb begin
		if (lvl_w < IW'(slm_pkg::LEVEL_MIN)) begin
			lvl_clamped = LW'(slm_pkg::LEVEL_MIN);
		end else if (lvl_w > IW'(slm_pkg::LEVEL_MAX)) begin
			lvl_clamped = LW'(slm_pkg::LEVEL_MAX);
		end else begin
			lvl_clamped = lvl_w[LW-1:0];
		end
	end

	assign old_w      = wrapped_q ? hist_rd_q : '0;
	assign total_next = total_q - TOT_W'(old_w) + TOT_W'(level_q);

	assign avg_prod = AP_W'(total_q) * AP_W'(REC_M);

	assign fin_go = (state_q == S_FIN) && (!out_valid_q || results.ready);

	always_comb begin
		if (level_q >= slm_pkg::TH_DANGEROUS) begin
			band_w = slm_pkg::BAND_DANGEROUS;
		end else if (level_q >= slm_pkg::TH_CRITICAL) begin
			band_w = slm_pkg::BAND_CRITICAL;
		end else if (level_q >= slm_pkg::TH_WARNING) begin
			band_w = slm_pkg::BAND_WARNING;
		end else if (level_q >= slm_pkg::TH_ELEVATED) begin
			band_w = slm_pkg::BAND_ELEVATED;
		end else begin
			band_w = slm_pkg::BAND_NORMAL;
		end
	end

	assign add95  = {1'b0, exp95_q} + (CW+1)'(secs_q);
	assign add110 = {1'b0, exp110_q} + (CW+1)'(secs_q);
	assign addimp = {1'b0, impacts_q} + (CW+1)'(1);

	always_comb begin
		peak_next    = (level_q > peak_q) ? level_q : peak_q;
		exp95_next   = exp95_q;
		exp110_next  = exp110_q;
		impacts_next = impacts_q;
		if (seen_q) begin
			if (level_q >= slm_pkg::TH_EXPOSE_LO) begin
				exp95_next = add95[CW] ? '1 : add95[CW-1:0];
			end
			if (level_q >= slm_pkg::TH_EXPOSE_HI) begin
				exp110_next = add110[CW] ? '1 : add110[CW-1:0];
			end
			if (level_q >= slm_pkg::TH_IMPACT) begin
				impacts_next = addimp[CW] ? '1 : addimp[CW-1:0];
			end
		end
		alert_w        = 1'b0;
		alert_mem_next = alert_mem_q;
		if (alert_en_q) begin
			if (band_w > slm_pkg::BAND_ELEVATED && band_w != alert_mem_q) begin
				alert_w        = 1'b1;
				alert_mem_next = band_w;
			end else if (band_w <= slm_pkg::BAND_ELEVATED) begin
				alert_mem_next = slm_pkg::BAND_NORMAL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_en_q  <= 1'b0;
			alert_en_q <= 1'b0;
			cal_off_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				slm_pkg::REG_MEASURE_ENABLE: meas_en_q  <= cfg.data[0];
				slm_pkg::REG_ALERT_ENABLE:   alert_en_q <= cfg.data[0];
				slm_pkg::REG_CAL_OFFSET:     cal_off_q  <= signed'(cfg.data[slm_pkg::CAL_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HIST) begin
			hist_mem[pos_q] <= level_q;
		end
		hist_rd_q <= hist_mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			sum_q       <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			wrapped_q   <= 1'b0;
			total_q     <= '0;
			peak_q      <= '0;
			exp95_q     <= '0;
			exp110_q    <= '0;
			impacts_q   <= '0;
			alert_mem_q <= slm_pkg::BAND_NORMAL;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
			rnd_q       <= '0;
			which_q     <= 1'b0;
		end else begin
			if (results.ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_ACC: begin
					if (in_fire && meas_en_q) begin
						if (samples.data.last) begin
							sum_q     <= '0;
							cnt_q     <= '0;
							blk_cnt_q <= cnt_next;
							secs_q    <= samples.data.elapsed_seconds;
							if (sum_next == '0) begin
								level_q <= LW'(slm_pkg::LEVEL_MIN);
								state_q <= S_HIST;
							end else begin
								norm_q  <= sum_next;
								exp_q   <= EXP_W'(SUM_W - 1);
								which_q <= 1'b0;
								state_q <= S_NORM;
							end
						end else begin
							sum_q <= sum_next;
							cnt_q <= cnt_next;
						end
					end
				end
				S_NORM: begin
					if (norm_q[SUM_W-1]) begin
						mant_q  <= norm_q[SUM_W-1 -: slm_pkg::MANT_W];
						frac_q  <= '0;
						rnd_q   <= '0;
						state_q <= S_SQR;
					end else begin
						norm_q <= {norm_q[SUM_W-2:0], 1'b0};
						exp_q  <= exp_q - EXP_W'(1);
					end
				end
				S_SQR: begin
					mant_q <= mant_next;
					frac_q <= frac_next;
					rnd_q  <= rnd_q + RND_W'(1);
					if (rnd_q == RND_W'(slm_pkg::SQR_ROUNDS - 1)) begin
						if (!which_q) begin
							lg_sum_q <= {exp_q, frac_next};
							norm_q   <= SUM_W'(blk_cnt_q);
							exp_q    <= EXP_W'(SUM_W - 1);
							which_q  <= 1'b1;
							state_q  <= S_NORM;
						end else begin
							lg_cnt_q <= {exp_q, frac_next};
							state_q  <= S_MUL;
						end
					end
				end
				S_MUL: begin
					prod_q  <= d_w * K_S;
					state_q <= S_LVL;
				end
				S_LVL: begin
					level_q <= lvl_clamped;
					state_q <= S_HIST;
				end
				S_HIST: begin
					total_q <= total_next;
					if (pos_q == POS_W'(AVERAGE_WINDOW - 1)) begin
						pos_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_q   <= LW'(avg_prod >> REC_SH);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						peak_q      <= peak_next;
						exp95_q     <= exp95_next;
						exp110_q    <= exp110_next;
						impacts_q   <= impacts_next;
						alert_mem_q <= alert_mem_next;
						seen_q      <= 1'b1;
						out_valid_q <= 1'b1;
						out_q.level_tenths         <= level_q;
						out_q.level_band           <= band_w;
						out_q.average_tenths       <= div_q;
						out_q.peak_tenths          <= peak_next;
						out_q.exposure_95_seconds  <= exp95_next;
						out_q.exposure_110_seconds <= exp110_next;
						out_q.impact_count         <= impacts_next;
						out_q.alert                <= alert_w;
						state_q <= S_ACC;
					end
				end
				default: state_q <= S_ACC;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.level_tenths >= LW'(slm_pkg::LEVEL_MIN)
			&& out_q.level_tenths <= LW'(slm_pkg::LEVEL_MAX)))
		else $error("result level outside clamp range");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_BLOCK_SAMPLES))
		else $error("block sample count passed its limit");

	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQR) |-> mant_q[slm_pkg::MANT_W-1])
		else $error("log2 mantissa not normalized");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (out_valid_q && state_q == S_ACC))
		else $error("block end did not present a result");

	a_avg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.average_tenths <= LW'(slm_pkg::LEVEL_MAX)
			&& out_q.peak_tenths >= out_q.level_tenths))
		else $error("average or peak inconsistent");
`endif

endmodule
